[design/stnh_pkg.sv]
// ----------------------------------------------------------------------------
// stnh_pkg: shared types and constants for the segment-triangle nearest hit
// Holds the fixed coordinate and fraction widths, the operand widths of the
// shared multiply-accumulate datapath, and the sequencer state encoding.
// ----------------------------------------------------------------------------
package stnh_pkg;

  localparam int CoordW  = 24;
  localparam int FracW   = 16;
  localparam int FracOutW = FracW + 1;
  localparam int DiffW   = CoordW + 1;
  localparam int CrossW  = 2 * DiffW + 1;
  localparam int DotW    = DiffW + CrossW + 2;
  localparam int DivCntW = $clog2(FracW + 2);
  localparam int LoW     = DiffW + 1;
  localparam int MulAW   = LoW + 1;
  localparam int ProdW   = MulAW + DiffW;
  localparam int MacSteps = 36;
  localparam int StepW   = $clog2(MacSteps + 1);

  localparam logic [FracOutW-1:0] FracOne = FracOutW'(1) << FracW;

  typedef enum logic [2:0] {
    RegStartX = 3'd0,
    RegStartY = 3'd1,
    RegStartZ = 3'd2,
    RegEndX   = 3'd3,
    RegEndY   = 3'd4,
    RegEndZ   = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StMac,
    StCheck,
    StDiv,
    StUpdate,
    StOut
  } state_e;

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;

endpackage

[design/stnh_divider.sv]
// ----------------------------------------------------------------------------
// stnh_divider: restoring divider for the hit fraction
// Computes floor(t * 2^FracW / d) for 0 <= t <= d, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module stnh_divider
  import stnh_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [DotW-1:0]   num_i,
  input  logic signed [DotW-1:0]   den_i,
  output div_ctl_t                 ctl_o,
  output logic [FracOutW-1:0]      quot_o
);

  logic [DotW:0]         rem_q, rem_d;
  logic [DotW-1:0]       den_q;
  logic [FracOutW-1:0]   quot_q, quot_d;
  logic [DivCntW-1:0]    cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic [DotW:0]         shifted;
  logic [DotW:0]         diff;

  always_comb begin
    shifted = rem_q;
    diff    = shifted - {1'b0, den_q};
    rem_d   = rem_q;
    quot_d  = quot_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    if (start_i) begin
      rem_d  = {1'b0, num_i};
      quot_d = '0;
      cnt_d  = DivCntW'(FracOutW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[DotW]) begin
        rem_d  = {diff[DotW-1:0], 1'b0};
        quot_d = {quot_q[FracOutW-2:0], 1'b1};
      end else begin
        rem_d  = {rem_q[DotW-1:0], 1'b0};
        quot_d = {quot_q[FracOutW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DivCntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    if (start_i) den_q <= den_i;
  end

  assign ctl_o.start = start_i;
  assign ctl_o.busy  = busy_q;
  assign quot_o      = quot_q;

endmodule

[design/stnh_mac.sv]
// ----------------------------------------------------------------------------
// stnh_mac: shared multiply-accumulate unit
// One signed partial product a cycle while enabled, optionally shifted up by
// the low-part width, added to or subtracted from the accumulator or zero.
// ----------------------------------------------------------------------------
module stnh_mac
  import stnh_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     clear_i,
  input  logic                     en_i,
  input  logic                     sub_i,
  input  logic                     shift_i,
  input  logic signed [MulAW-1:0]  a_i,
  input  logic signed [DiffW-1:0]  b_i,
  output logic signed [DotW-1:0]   acc_o
);

  logic signed [DotW-1:0]  acc_q, acc_d;
  logic signed [ProdW-1:0] prod;
  logic signed [DotW-1:0]  term;

  assign prod = a_i * b_i;
  assign term = shift_i ? (DotW'(prod) <<< LoW) : DotW'(prod);

  always_comb begin
    acc_d = acc_q;
    if (en_i) begin
      acc_d = (clear_i ? '0 : acc_q) + (sub_i ? -term : term);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

[design/segment_triangle_nearest_hit.sv]
// ----------------------------------------------------------------------------
// segment_triangle_nearest_hit: nearest hit of a segment over a triangle mesh
// Runs the one-sided segment-triangle test per triangle on one shared
// multiply-accumulate unit, divides for the hit fraction, keeps the minimum.
//
//   channel  direction  handshake         payload
//   tri      in         tri_valid/stall   corner_*, last_triangle
//   res      out        res_valid/stall   any_hit, nearest_fraction
//   cfg      in         cfg_valid/ready   cfg_index, cfg_data
//
// A triangle passes through an accept, the MAC steps (each dot term as two
// partial products), a check, the divider on a hit, and an update.
// The triangle channel is stalled while an item is in flight; a last triangle
// holds in update while an earlier result still waits.
// Reset clears control state, end points, hit flag; sets best fraction to 1.0.
// ----------------------------------------------------------------------------
module segment_triangle_nearest_hit
  import stnh_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     tri_valid_i,
  output logic                     tri_stall_o,
  input  logic signed [CoordW-1:0] corner_a_x_i,
  input  logic signed [CoordW-1:0] corner_a_y_i,
  input  logic signed [CoordW-1:0] corner_a_z_i,
  input  logic signed [CoordW-1:0] corner_b_x_i,
  input  logic signed [CoordW-1:0] corner_b_y_i,
  input  logic signed [CoordW-1:0] corner_b_z_i,
  input  logic signed [CoordW-1:0] corner_c_x_i,
  input  logic signed [CoordW-1:0] corner_c_y_i,
  input  logic signed [CoordW-1:0] corner_c_z_i,
  input  logic                     last_triangle_i,
  output logic                     res_valid_o,
  input  logic                     res_stall_i,
  output logic                     any_hit_o,
  output logic [FracOutW-1:0]      nearest_fraction_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [2:0]               cfg_index_i,
  input  logic [CoordW-1:0]        cfg_data_i
);

  logic signed [CoordW-1:0] p_q [3];
  logic signed [CoordW-1:0] e_q [3];
  logic signed [DiffW-1:0]  ab_q [3], ac_q [3], ap_q [3], qp_q [3];
  logic signed [CrossW-1:0] n_q [3], x_q [3];
  logic signed [DotW-1:0]   d_q, t_q, v_q;
  logic                     last_q;
  logic                     hit_q, hit_d;
  logic [FracOutW-1:0]      best_q, best_d;
  logic                     res_valid_q, res_valid_d;
  logic                     res_hit_q;
  logic [FracOutW-1:0]      res_frac_q;
  logic [StepW-1:0]         step_q, step_d;
  state_e                   state_q, state_d;

  logic                     mac_clear, mac_sub, mac_shift;
  logic signed [MulAW-1:0]  mac_a;
  logic signed [DiffW-1:0]  mac_b;
  logic signed [DotW-1:0]   acc;
  logic                     mac_en;
  logic                     tri_fire;
  logic                     res_free;
  logic                     is_hit;
  logic                     div_start;
  div_ctl_t                 div_ctl;
  logic [FracOutW-1:0]      quot;

  function automatic logic signed [MulAW-1:0] lo_part(logic signed [CrossW-1:0] x);
    return MulAW'({1'b0, x[LoW-1:0]});
  endfunction

  function automatic logic signed [MulAW-1:0] hi_part(logic signed [CrossW-1:0] x);
    return MulAW'($signed(x[CrossW-1:LoW]));
  endfunction

  assign tri_fire    = tri_valid_i && !tri_stall_o;
  assign tri_stall_o = (state_q != StIdle);
  assign cfg_ready_o = (state_q == StIdle);
  assign res_free    = !res_valid_q || !res_stall_i;

  // step schedule: 0..11 build the cross products n and x, two products per
  // component; 12..35 form the dots d, t, v and w, each term as a low and a
  // shifted high partial product. Capture each value the step after its last
  // term; w stays in the accumulator.
  always_comb begin
    mac_a     = '0;
    mac_b     = '0;
    mac_sub   = 1'b0;
    mac_clear = 1'b0;
    mac_shift = 1'b0;
    case (step_q)
      6'd0:  begin mac_a = MulAW'(ab_q[1]); mac_b = ac_q[2]; mac_clear = 1'b1; end
      6'd1:  begin mac_a = MulAW'(ab_q[2]); mac_b = ac_q[1]; mac_sub = 1'b1; end
      6'd2:  begin mac_a = MulAW'(ab_q[2]); mac_b = ac_q[0]; mac_clear = 1'b1; end
      6'd3:  begin mac_a = MulAW'(ab_q[0]); mac_b = ac_q[2]; mac_sub = 1'b1; end
      6'd4:  begin mac_a = MulAW'(ab_q[0]); mac_b = ac_q[1]; mac_clear = 1'b1; end
      6'd5:  begin mac_a = MulAW'(ab_q[1]); mac_b = ac_q[0]; mac_sub = 1'b1; end
      6'd6:  begin mac_a = MulAW'(qp_q[1]); mac_b = ap_q[2]; mac_clear = 1'b1; end
      6'd7:  begin mac_a = MulAW'(qp_q[2]); mac_b = ap_q[1]; mac_sub = 1'b1; end
      6'd8:  begin mac_a = MulAW'(qp_q[2]); mac_b = ap_q[0]; mac_clear = 1'b1; end
      6'd9:  begin mac_a = MulAW'(qp_q[0]); mac_b = ap_q[2]; mac_sub = 1'b1; end
      6'd10: begin mac_a = MulAW'(qp_q[0]); mac_b = ap_q[1]; mac_clear = 1'b1; end
      6'd11: begin mac_a = MulAW'(qp_q[1]); mac_b = ap_q[0]; mac_sub = 1'b1; end
      6'd12: begin mac_a = lo_part(n_q[0]); mac_b = qp_q[0]; mac_clear = 1'b1; end
      6'd13: begin mac_a = hi_part(n_q[0]); mac_b = qp_q[0]; mac_shift = 1'b1; end
      6'd14: begin mac_a = lo_part(n_q[1]); mac_b = qp_q[1]; end
      6'd15: begin mac_a = hi_part(n_q[1]); mac_b = qp_q[1]; mac_shift = 1'b1; end
      6'd16: begin mac_a = lo_part(n_q[2]); mac_b = qp_q[2]; end
      6'd17: begin mac_a = hi_part(n_q[2]); mac_b = qp_q[2]; mac_shift = 1'b1; end
      6'd18: begin mac_a = lo_part(n_q[0]); mac_b = ap_q[0]; mac_clear = 1'b1; end
      6'd19: begin mac_a = hi_part(n_q[0]); mac_b = ap_q[0]; mac_shift = 1'b1; end
      6'd20: begin mac_a = lo_part(n_q[1]); mac_b = ap_q[1]; end
      6'd21: begin mac_a = hi_part(n_q[1]); mac_b = ap_q[1]; mac_shift = 1'b1; end
      6'd22: begin mac_a = lo_part(n_q[2]); mac_b = ap_q[2]; end
      6'd23: begin mac_a = hi_part(n_q[2]); mac_b = ap_q[2]; mac_shift = 1'b1; end
      6'd24: begin mac_a = lo_part(x_q[0]); mac_b = ac_q[0]; mac_clear = 1'b1; end
      6'd25: begin mac_a = hi_part(x_q[0]); mac_b = ac_q[0]; mac_shift = 1'b1; end
      6'd26: begin mac_a = lo_part(x_q[1]); mac_b = ac_q[1]; end
      6'd27: begin mac_a = hi_part(x_q[1]); mac_b = ac_q[1]; mac_shift = 1'b1; end
      6'd28: begin mac_a = lo_part(x_q[2]); mac_b = ac_q[2]; end
      6'd29: begin mac_a = hi_part(x_q[2]); mac_b = ac_q[2]; mac_shift = 1'b1; end
      6'd30: begin
        mac_a     = lo_part(x_q[0]);
        mac_b     = ab_q[0];
        mac_clear = 1'b1;
        mac_sub   = 1'b1;
      end
      6'd31: begin
        mac_a     = hi_part(x_q[0]);
        mac_b     = ab_q[0];
        mac_shift = 1'b1;
        mac_sub   = 1'b1;
      end
      6'd32: begin mac_a = lo_part(x_q[1]); mac_b = ab_q[1]; mac_sub = 1'b1; end
      6'd33: begin
        mac_a     = hi_part(x_q[1]);
        mac_b     = ab_q[1];
        mac_shift = 1'b1;
        mac_sub   = 1'b1;
      end
      6'd34: begin mac_a = lo_part(x_q[2]); mac_b = ab_q[2]; mac_sub = 1'b1; end
      6'd35: begin
        mac_a     = hi_part(x_q[2]);
        mac_b     = ab_q[2];
        mac_shift = 1'b1;
        mac_sub   = 1'b1;
      end
      default: ;
    endcase
  end

  assign mac_en = (state_q == StMac);

  stnh_mac u_mac (
    .clk_i   (clk_i),
    .clear_i (mac_clear),
    .en_i    (mac_en),
    .sub_i   (mac_sub),
    .shift_i (mac_shift),
    .a_i     (mac_a),
    .b_i     (mac_b),
    .acc_o   (acc)
  );

  assign is_hit = (d_q > 0) && (t_q >= 0) && (t_q <= d_q) && (v_q >= 0) &&
                  (v_q <= d_q) && (acc >= 0) && ((v_q + acc) <= d_q);
  assign div_start = (state_q == StCheck) && is_hit;

  stnh_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (t_q),
    .den_i   (d_q),
    .ctl_o   (div_ctl),
    .quot_o  (quot)
  );

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      StIdle: if (tri_fire) begin
        state_d = StMac;
        step_d  = '0;
      end
      StMac: begin
        step_d = step_q + 1'b1;
        if (step_q == StepW'(MacSteps - 1)) state_d = StCheck;
      end
      StCheck:  state_d = is_hit ? StDiv : StUpdate;
      StDiv:    if (!div_ctl.busy && !div_ctl.start) state_d = StUpdate;
      StUpdate: if (!last_q || res_free) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_comb begin
    hit_d       = hit_q;
    best_d      = best_q;
    res_valid_d = res_valid_q && res_stall_i;
    if (state_q == StDiv && !div_ctl.busy && !div_ctl.start) begin
      hit_d = 1'b1;
      if (quot < best_q) best_d = quot;
    end
    if (state_q == StUpdate && last_q && res_free) begin
      res_valid_d = 1'b1;
      hit_d       = 1'b0;
      best_d      = FracOne;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      hit_q       <= 1'b0;
      best_q      <= FracOne;
      res_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        p_q[i] <= '0;
        e_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      hit_q       <= hit_d;
      best_q      <= best_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegStartX: p_q[0] <= cfg_data_i;
          RegStartY: p_q[1] <= cfg_data_i;
          RegStartZ: p_q[2] <= cfg_data_i;
          RegEndX:   e_q[0] <= cfg_data_i;
          RegEndY:   e_q[1] <= cfg_data_i;
          RegEndZ:   e_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tri_fire) begin
      ab_q[0] <= DiffW'(corner_b_x_i) - DiffW'(corner_a_x_i);
      ab_q[1] <= DiffW'(corner_b_y_i) - DiffW'(corner_a_y_i);
      ab_q[2] <= DiffW'(corner_b_z_i) - DiffW'(corner_a_z_i);
      ac_q[0] <= DiffW'(corner_c_x_i) - DiffW'(corner_a_x_i);
      ac_q[1] <= DiffW'(corner_c_y_i) - DiffW'(corner_a_y_i);
      ac_q[2] <= DiffW'(corner_c_z_i) - DiffW'(corner_a_z_i);
      ap_q[0] <= DiffW'(p_q[0]) - DiffW'(corner_a_x_i);
      ap_q[1] <= DiffW'(p_q[1]) - DiffW'(corner_a_y_i);
      ap_q[2] <= DiffW'(p_q[2]) - DiffW'(corner_a_z_i);
      for (int i = 0; i < 3; i++) qp_q[i] <= DiffW'(p_q[i]) - DiffW'(e_q[i]);
      last_q <= last_triangle_i;
    end
    if (state_q == StMac) begin
      case (step_q)
        6'd2:  n_q[0] <= CrossW'(acc);
        6'd4:  n_q[1] <= CrossW'(acc);
        6'd6:  n_q[2] <= CrossW'(acc);
        6'd8:  x_q[0] <= CrossW'(acc);
        6'd10: x_q[1] <= CrossW'(acc);
        6'd12: x_q[2] <= CrossW'(acc);
        6'd18: d_q    <= acc;
        6'd24: t_q    <= acc;
        6'd30: v_q    <= acc;
        default: ;
      endcase
    end
    if (state_q == StUpdate && last_q && res_free) begin
      res_hit_q  <= hit_q;
      res_frac_q <= best_q;
    end
  end

  assign res_valid_o        = res_valid_q;
  assign any_hit_o          = res_hit_q;
  assign nearest_fraction_o = res_frac_q;

endmodule
